### design/ssrs_pkg.sv
package ssrs_pkg;

  // Fixed geometry of the policy tables
  localparam int SETS        = 2048;
  localparam int SET_W       = 11;
  localparam int SIG_ENTRIES = 4096;
  localparam int SIG_W       = 12;

  // Field widths
  localparam int PC_W        = 64;
  localparam int ADDR_W      = 64;
  localparam int BLOCK_SHIFT = 6;
  localparam int BLK_W       = ADDR_W - BLOCK_SHIFT;
  localparam int STRIDE_W    = BLK_W + 1;
  localparam int REP_W       = 8;
  localparam int CTR_W       = 2;
  localparam int WAY_IN_W    = 4;
  localparam int OUT_WAY_W   = 4;

  // Signature hash taps: sig = (pc >> 2) ^ (pc >> 12)
  localparam int HASH_LO = 2;
  localparam int HASH_HI = 12;

  // Clearing pass walks the deeper of the two tables
  localparam int CLR_W = SIG_W;

  localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0] CTR_INIT = 2'd1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOT_THRESHOLD  = 2'd0,
    CFG_STREAM_RUN     = 2'd1,
    CFG_SMALL_STRIDE   = 2'd2
  } cfg_idx_t;

  localparam logic [CTR_W-1:0] HOT_THR_RST      = 2'd2;
  localparam logic [REP_W-1:0] STREAM_RUN_RST   = 8'd2;
  localparam logic [REP_W-1:0] SMALL_STRIDE_RST = 8'd8;

  // Opcodes
  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Per-signature training entry (previous block is kept in its own lane)
  typedef struct packed {
    logic [CTR_W-1:0]    ctr;
    logic                pbv;
    logic [STRIDE_W-1:0] stride;
    logic [REP_W-1:0]    rep;
  } sig_meta_t;

  localparam sig_meta_t META_CLEAR = '{
    ctr:    CTR_INIT,
    pbv:    1'b0,
    stride: '0,
    rep:    '0
  };

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_ROW  = 6'b000100,
    S_OLD  = 6'b001000,
    S_NEW  = 6'b010000,
    S_FILL = 6'b100000
  } state_t;

endpackage

### design/ssrs_if.sv
interface ssrs_in_if import ssrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SET_W-1:0]    set_index;
  logic [WAY_IN_W-1:0] way_index;
  logic                hit;
  logic [PC_W-1:0]     pc;
  logic [ADDR_W-1:0]   paddr;

  modport source (output valid, opcode, set_index, way_index, hit, pc, paddr,
                  input ready);
  modport sink   (input valid, opcode, set_index, way_index, hit, pc, paddr,
                  output ready);
endinterface

interface ssrs_out_if import ssrs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_WAY_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

### design/ssrs_victim.sv
module ssrs_victim #(
  parameter int WAYS       = 16,
  parameter int RRPV_WIDTH = 3
) (
  input  logic [WAYS-1:0][RRPV_WIDTH-1:0] rrpv,
  output logic [WAYS-1:0][RRPV_WIDTH-1:0] aged,
  output logic [$clog2(WAYS)-1:0]         victim
);

  localparam int WAY_W  = $clog2(WAYS);
  localparam int LEVELS = 1 << RRPV_WIDTH;
  localparam logic [RRPV_WIDTH-1:0] RRPV_CEIL = '1;

  logic [LEVELS-1:0]     present;
  logic [RRPV_WIDTH-1:0] top;
  logic [RRPV_WIDTH-1:0] lift;

  // Largest value in the set: mark which levels occur, take the highest
  always_comb begin
    present = '0;
    for (int w = 0; w < WAYS; w++) begin
      present[rrpv[w]] = 1'b1;
    end
    top = '0;
    for (int v = 0; v < LEVELS; v++) begin
      if (present[v]) begin
        top = RRPV_WIDTH'(v);
      end
    end
  end

  // Ageing lifts every way by the same amount so the largest lands on max
  assign lift = RRPV_CEIL - top;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      aged[w] = rrpv[w] + lift;
    end
  end

  // First way holding the largest value becomes the victim
  always_comb begin
    victim = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rrpv[w] == top) begin
        victim = WAY_W'(w);
      end
    end
  end

endmodule

### design/ship_srrip_stream_replacement_top.sv
// Replacement policy for a last-level cache: SRRIP ageing, a per-signature hit
// predictor and a small-stride stream detector. Items are taken one at a time.
// A victim request passes through S_ROW, a hit update through S_ROW and S_OLD,
// a miss update with fill through S_ROW, S_OLD, S_NEW and S_FILL (an update to
// a way beyond WAYS leaves from S_ROW and does nothing); the sequence is set by
// the single read port of the set-row memory and of the signature memory, which
// a miss visits twice (evicted and new signature). After reset a clearing pass
// over all 4096 signature entries initializes both memories while in_ch.ready
// stays low; configuration writes take effect at once and belong between items,
// while nothing is in flight. Results sit in an output register. The next item
// is still accepted while a result waits there, but a victim request then stays
// in S_ROW until the register is free.
module ship_srrip_stream_replacement_top import ssrs_pkg::*; #(
  parameter int WAYS       = 16,
  parameter int RRPV_WIDTH = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ssrs_in_if.sink               in_ch,
  ssrs_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WAY_W = $clog2(WAYS);
  localparam logic [RRPV_WIDTH-1:0] RRPV_CEIL   = '1;
  localparam logic [RRPV_WIDTH-1:0] RRPV_WARM   = RRPV_CEIL - RRPV_WIDTH'(1);
  localparam logic [RRPV_WIDTH-1:0] RRPV_STREAM = RRPV_CEIL - RRPV_WIDTH'(2);

  typedef struct packed {
    logic [WAYS-1:0][RRPV_WIDTH-1:0] rrpv;
    logic [WAYS-1:0][SIG_W-1:0]      fsig;
    logic [WAYS-1:0]                 hsf;
  } row_t;

  // Control
  state_t            state_r, state_nxt;
  logic [CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic              in_xfer;
  logic              out_free;
  logic              victim_done;

  // Configuration
  logic [CTR_W-1:0]      hot_thr_r;
  logic [REP_W-1:0]      run_need_r;
  logic [CFG_DATA_W-1:0] small_lim_r;

  // Item held for the duration of its work
  logic             op_r;
  logic [SET_W-1:0] set_r;
  logic [WAY_W-1:0] way_r;
  logic             way_ok_r;
  logic             hit_r;
  logic [SIG_W-1:0] nsig_r;
  logic [BLK_W-1:0] blk_r;

  // Set-row memory
  row_t             row_mem [SETS];
  row_t             row_rd;
  row_t             row_wd;
  row_t             row_clr;
  logic             row_we;
  logic [SET_W-1:0] row_wa;

  // Signature memory: training lane and previous-block lane share an address
  sig_meta_t        meta_mem [SIG_ENTRIES];
  logic [BLK_W-1:0] pb_mem   [SIG_ENTRIES];
  sig_meta_t        meta_rd;
  logic [BLK_W-1:0] pb_rd;
  sig_meta_t        meta_wd;
  logic             meta_we;
  logic             pb_we;
  logic             sig_re;
  logic [SIG_W-1:0] sig_ra;
  logic [SIG_W-1:0] sig_wa;

  // Datapath
  logic [SIG_W-1:0]    old_sig;
  logic                old_hsf;
  sig_meta_t           meta_upd;
  sig_meta_t           fwd_r;
  sig_meta_t           meta_cur;
  sig_meta_t           cur_r;
  logic signed [STRIDE_W-1:0] diff_r;
  logic signed [STRIDE_W-1:0] lim_pos;
  logic signed [STRIDE_W-1:0] lim_neg;
  logic                stride_eq;
  logic [REP_W-1:0]    rep_n;
  logic [STRIDE_W-1:0] stride_n;
  logic                stream;
  logic [RRPV_WIDTH-1:0] ins;
  logic [WAYS-1:0][RRPV_WIDTH-1:0] aged;
  logic [WAY_W-1:0]    vic_way;
  logic [WAY_W+OUT_WAY_W-1:0] vic_ext;
  logic [WAY_W+WAY_IN_W-1:0]  way_ext;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.victim_way = out_way_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_thr_r   <= HOT_THR_RST;
      run_need_r  <= STREAM_RUN_RST;
      small_lim_r <= SMALL_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HOT_THRESHOLD: hot_thr_r   <= cfg_wdata[CTR_W-1:0];
        CFG_STREAM_RUN:    run_need_r  <= cfg_wdata[REP_W-1:0];
        CFG_SMALL_STRIDE:  small_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the item at the transfer
  assign way_ext = {{WAY_W{1'b0}}, in_ch.way_index};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_ch.opcode;
      set_r    <= in_ch.set_index;
      way_r    <= way_ext[WAY_W-1:0];
      way_ok_r <= (32'(in_ch.way_index) < 32'(WAYS));
      hit_r    <= in_ch.hit;
      nsig_r   <= in_ch.pc[HASH_LO+SIG_W-1:HASH_LO] ^ in_ch.pc[HASH_HI+SIG_W-1:HASH_HI];
      blk_r    <= in_ch.paddr[ADDR_W-1:BLOCK_SHIFT];
    end
  end

  // Set-row memory, one write and one registered read per cycle; the read happens at an input transfer
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (in_xfer) begin
      row_rd <= row_mem[in_ch.set_index];
    end
  end

  // Signature memory; the previous-block lane is written only on fills
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[sig_wa] <= meta_wd;
    end
    if (pb_we) begin
      pb_mem[sig_wa] <= blk_r;
    end
    if (sig_re) begin
      meta_rd <= meta_mem[sig_ra];
      pb_rd   <= pb_mem[sig_ra];
    end
  end

  ssrs_victim #(
    .WAYS       (WAYS),
    .RRPV_WIDTH (RRPV_WIDTH)
  ) u_victim (
    .rrpv   (row_rd.rrpv),
    .aged   (aged),
    .victim (vic_way)
  );

  assign vic_ext = {{OUT_WAY_W{1'b0}}, vic_way};

  assign old_sig = row_rd.fsig[way_r];
  assign old_hsf = row_rd.hsf[way_r];

  // Train the signature the block was filled under
  always_comb begin
    meta_upd = meta_rd;
    if (hit_r) begin
      if (meta_rd.ctr != CTR_MAX) begin
        meta_upd.ctr = meta_rd.ctr + CTR_W'(1);
      end
    end else if (!old_hsf && (meta_rd.ctr != '0)) begin
      meta_upd.ctr = meta_rd.ctr - CTR_W'(1);
    end
  end

  // Read of the new signature races the write of the old one: forward
  assign meta_cur = (nsig_r == old_sig) ? fwd_r : meta_rd;

  always_ff @(posedge clk) begin
    if (state_r == S_OLD) begin
      fwd_r <= meta_upd;
    end
    if (state_r == S_NEW) begin
      cur_r  <= meta_cur;
      diff_r <= $signed({1'b0, blk_r}) - $signed({1'b0, pb_rd});
    end
  end

  // Stride detector and insertion value
  assign lim_pos   = $signed({{(STRIDE_W-CFG_DATA_W){1'b0}}, small_lim_r});
  assign lim_neg   = -lim_pos;
  assign stride_eq = (diff_r == $signed(cur_r.stride));

  always_comb begin
    if (cur_r.pbv) begin
      rep_n    = stride_eq ? cur_r.rep + REP_W'(1) : REP_W'(1);
      stride_n = diff_r;
      stream   = (rep_n >= run_need_r) && (diff_r <= lim_pos) && (diff_r >= lim_neg);
    end else begin
      rep_n    = REP_W'(1);
      stride_n = '0;
      stream   = 1'b0;
    end
    if (cur_r.ctr >= hot_thr_r) begin
      ins = '0;
    end else if (stream) begin
      ins = RRPV_STREAM;
    end else if (cur_r.ctr != '0) begin
      ins = RRPV_WARM;
    end else begin
      ins = RRPV_CEIL;
    end
  end

  always_comb begin
    row_clr      = '0;
    row_clr.rrpv = {WAYS{RRPV_CEIL}};
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    victim_done = 1'b0;
    row_we      = 1'b0;
    row_wa      = set_r;
    row_wd      = row_rd;
    sig_re      = 1'b0;
    sig_ra      = old_sig;
    meta_we     = 1'b0;
    pb_we       = 1'b0;
    sig_wa      = old_sig;
    meta_wd     = meta_upd;
    unique case (state_r)
      S_CLR: begin
        row_we  = (clr_cnt_r < CLR_W'(SETS));
        row_wa  = clr_cnt_r[SET_W-1:0];
        row_wd  = row_clr;
        meta_we = 1'b1;
        sig_wa  = clr_cnt_r[SIG_W-1:0];
        meta_wd = META_CLEAR;
        if (clr_cnt_r == CLR_W'(SIG_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        if (op_r == OP_VICTIM) begin
          if (out_free) begin
            victim_done = 1'b1;
            row_we      = 1'b1;
            row_wd.rrpv = aged;
            state_nxt   = S_IDLE;
          end
        end else if (!way_ok_r) begin
          state_nxt = S_IDLE;
        end else begin
          sig_re = 1'b1;
          sig_ra = old_sig;
          if (hit_r) begin
            row_we             = 1'b1;
            row_wd.rrpv[way_r] = '0;
            row_wd.hsf[way_r]  = 1'b1;
          end
          state_nxt = S_OLD;
        end
      end
      S_OLD: begin
        sig_wa = old_sig;
        if (hit_r) begin
          meta_we   = !old_hsf;
          state_nxt = S_IDLE;
        end else begin
          meta_we   = 1'b1;
          sig_re    = 1'b1;
          sig_ra    = nsig_r;
          state_nxt = S_NEW;
        end
      end
      S_NEW: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        meta_we = 1'b1;
        pb_we   = 1'b1;
        sig_wa  = nsig_r;
        meta_wd = '{ctr: cur_r.ctr, pbv: 1'b1, stride: stride_n, rep: rep_n};
        row_we             = 1'b1;
        row_wd.rrpv[way_r] = ins;
        row_wd.fsig[way_r] = nsig_r;
        row_wd.hsf[way_r]  = 1'b0;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // Output register
  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || victim_done;

  always_ff @(posedge clk) begin
    if (victim_done) begin
      out_way_r <= vic_ext[OUT_WAY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/ssrs_checker.sv
module ssrs_checker import ssrs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_WAY_W-1:0] out_victim_way
);

  // Reset starts the clearing pass: nothing taken, nothing shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ssrs: ready or result right after reset");

  // One item at a time: a transfer closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ssrs: input ready again right after a transfer");

  // An update never produces a result
  a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_UPDATE) && !out_valid |=> !out_valid)
    else $error("ssrs: result after an update");

  // A victim request with an empty output shows its result after S_ROW loads the output register
  a_victim_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_VICTIM) && !out_valid |-> ##2 out_valid)
    else $error("ssrs: victim result missing");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_way))
    else $error("ssrs: stalled result changed");

endmodule

bind ship_srrip_stream_replacement_top ssrs_checker u_ssrs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_opcode      (in_ch.opcode),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_victim_way (out_ch.victim_way)
);

### tb/sv/ssrs_victim_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the register port, keeps its own copy of the
// replacement state and checks every victim transfer in order.
module ssrs_victim_checker import ssrs_pkg::*; #(
  parameter int WAYS       = 16,
  parameter int RRPV_WIDTH = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ssrs_in_if                    in_mon,
  ssrs_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    victims_owed
);

  localparam int SLOTS = SETS * WAYS;
  localparam logic [RRPV_WIDTH-1:0] RRPV_CEIL = '1;

  // Per-block state
  logic [RRPV_WIDTH-1:0] rrpv_tab  [SLOTS];
  logic [SIG_W-1:0]      owner_sig [SLOTS];
  logic                  reused    [SLOTS];

  // Per-signature state
  logic [CTR_W-1:0]           sig_ctr     [SIG_ENTRIES];
  logic                       last_blk_ok [SIG_ENTRIES];
  logic [BLK_W-1:0]           last_blk    [SIG_ENTRIES];
  logic signed [STRIDE_W-1:0] seen_stride [SIG_ENTRIES];
  logic [REP_W-1:0]           run_len     [SIG_ENTRIES];

  // Register copies
  logic [CTR_W-1:0] hot_thr;
  logic [REP_W-1:0] run_need;
  logic [REP_W-1:0] stride_lim;

  logic [OUT_WAY_W-1:0] victims_q [$];
  int err_total = 0;

  task automatic note_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    err_total++;
  endtask

  // Age the set until some way reaches the maximum, return the first such way
  function automatic logic [OUT_WAY_W-1:0] age_and_pick(input int set_no);
    int base;
    int w;
    logic [RRPV_WIDTH-1:0] top_val;
    logic [RRPV_WIDTH-1:0] lift;
    logic [OUT_WAY_W-1:0] pick;
    logic found;
    base = set_no * WAYS;
    top_val = '0;
    for (w = 0; w < WAYS; w++) begin
      if (rrpv_tab[base + w] > top_val) top_val = rrpv_tab[base + w];
    end
    lift = RRPV_CEIL - top_val;
    for (w = 0; w < WAYS; w++) rrpv_tab[base + w] = rrpv_tab[base + w] + lift;
    pick = '0;
    found = 1'b0;
    for (w = 0; w < WAYS; w++) begin
      if (!found && rrpv_tab[base + w] == RRPV_CEIL) begin
        pick = OUT_WAY_W'(w);
        found = 1'b1;
      end
    end
    return pick;
  endfunction

  // Hit promotion / fill training and insertion
  function automatic void train_access(input int slot, input logic hit_flag,
                                       input logic [PC_W-1:0] pc_v,
                                       input logic [ADDR_W-1:0] addr_v);
    logic [SIG_W-1:0] old_sig;
    logic [SIG_W-1:0] new_sig;
    logic [BLK_W-1:0] blk;
    logic signed [STRIDE_W-1:0] delta;
    longint span;
    longint lim;
    logic stream;
    logic [RRPV_WIDTH-1:0] ins;
    if (hit_flag) begin
      if (!reused[slot]) begin
        if (sig_ctr[owner_sig[slot]] != CTR_MAX)
          sig_ctr[owner_sig[slot]] = sig_ctr[owner_sig[slot]] + 1'b1;
        reused[slot] = 1'b1;
      end
      rrpv_tab[slot] = '0;
      return;
    end
    // evicted block never reused: its signature loses confidence
    old_sig = owner_sig[slot];
    if (!reused[slot] && sig_ctr[old_sig] != '0)
      sig_ctr[old_sig] = sig_ctr[old_sig] - 1'b1;
    new_sig = pc_v[HASH_LO +: SIG_W] ^ pc_v[HASH_HI +: SIG_W];
    blk = addr_v[ADDR_W-1:BLOCK_SHIFT];
    stream = 1'b0;
    if (last_blk_ok[new_sig]) begin
      delta = $signed({1'b0, blk}) - $signed({1'b0, last_blk[new_sig]});
      if (delta == seen_stride[new_sig]) begin
        run_len[new_sig] = run_len[new_sig] + 1'b1;
      end else begin
        seen_stride[new_sig] = delta;
        run_len[new_sig] = 1;
      end
      span = seen_stride[new_sig];
      lim = longint'(stride_lim);
      stream = (run_len[new_sig] >= run_need) && (span <= lim) && (span >= -lim);
    end else begin
      run_len[new_sig] = 1;
      seen_stride[new_sig] = '0;
    end
    last_blk[new_sig] = blk;
    last_blk_ok[new_sig] = 1'b1;
    if (sig_ctr[new_sig] >= hot_thr) ins = '0;
    else if (stream) ins = RRPV_CEIL - 2;
    else if (sig_ctr[new_sig] != '0) ins = RRPV_CEIL - 1;
    else ins = RRPV_CEIL;
    rrpv_tab[slot] = ins;
    owner_sig[slot] = new_sig;
    reused[slot] = 1'b0;
  endfunction

  // Track transfers at each rising edge; counters are published by nonblocking assignment
  always @(posedge clk) begin
    int i;
    logic [OUT_WAY_W-1:0] want;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) begin
        rrpv_tab[i] = RRPV_CEIL;
        owner_sig[i] = '0;
        reused[i] = 1'b0;
      end
      for (i = 0; i < SIG_ENTRIES; i++) begin
        sig_ctr[i] = CTR_INIT;
        last_blk_ok[i] = 1'b0;
        last_blk[i] = '0;
        seen_stride[i] = '0;
        run_len[i] = '0;
      end
      hot_thr = HOT_THR_RST;
      run_need = STREAM_RUN_RST;
      stride_lim = SMALL_STRIDE_RST;
      victims_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HOT_THRESHOLD: hot_thr = cfg_wdata[CTR_W-1:0];
          CFG_STREAM_RUN:    run_need = cfg_wdata[REP_W-1:0];
          CFG_SMALL_STRIDE:  stride_lim = cfg_wdata[REP_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_VICTIM) begin
          victims_q.push_back(age_and_pick(int'(in_mon.set_index) % SETS));
        end else if (int'(in_mon.way_index) < WAYS) begin
          train_access((int'(in_mon.set_index) % SETS) * WAYS + int'(in_mon.way_index),
                       in_mon.hit, in_mon.pc, in_mon.paddr);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (victims_q.size() == 0) begin
          note_mismatch($sformatf("unexpected victim transfer, way %0d",
                                  out_mon.victim_way));
        end else begin
          want = victims_q.pop_front();
          if (out_mon.victim_way !== want)
            note_mismatch($sformatf("victim_way got %0d want %0d",
                                    out_mon.victim_way, want));
        end
      end
    end
    mismatches <= err_total;
    victims_owed <= victims_q.size();
  end

endmodule

### tb/sv/tb_ship_srrip_stream_replacement_top.sv
`timescale 1ns / 1ps
module tb_ship_srrip_stream_replacement_top;
  import ssrs_pkg::*;

  localparam int N_PCS  = 12;
  localparam int N_SETS = 8;
  localparam logic [PC_W-1:0] STREAM_PC = 64'h0000_0000_0040_1000;
  localparam logic [PC_W-1:0] DOWN_PC   = 64'h0000_7fff_1234_5678;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int mismatches;
  int victims_owed;

  // Stimulus state
  logic calm;
  logic out_steady;
  int cur_limit;
  logic [PC_W-1:0]   pc_pool    [N_PCS];
  logic [ADDR_W-1:0] cursor     [N_PCS];
  longint            stride_blk [N_PCS];
  logic [SET_W-1:0]  set_pool   [N_SETS];

  ssrs_in_if  in_ch();
  ssrs_out_if out_ch();

  ship_srrip_stream_replacement_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssrs_victim_checker victim_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .victims_owed (victims_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one; none while quiet
  function automatic int idle_len(input logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stride in blocks, biased toward the current small-stride bound
  function automatic longint new_stride();
    longint s;
    case ($urandom_range(0, 9))
      0:       s = 0;
      1, 2, 3: s = $urandom_range(1, 4);
      4:       s = cur_limit;
      5:       s = cur_limit + 1;
      6:       s = $urandom_range(1, 255);
      7:       s = $urandom;
      default: s = 1;
    endcase
    if ($urandom_range(0, 1) == 1) s = -s;
    return s;
  endfunction

  function automatic logic [SET_W-1:0] pick_set();
    if ($urandom_range(0, 99) < 85) return set_pool[$urandom_range(0, N_SETS - 1)];
    return SET_W'($urandom);
  endfunction

  // One transfer on the input channel, after an optional gap
  task automatic send(input logic op, input logic [SET_W-1:0] set_no,
                      input logic [WAY_IN_W-1:0] way, input logic hit_flag,
                      input logic [PC_W-1:0] pc_v, input logic [ADDR_W-1:0] addr_v);
    int gap;
    gap = idle_len(calm);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.set_index <= set_no;
    in_ch.way_index <= way;
    in_ch.hit       <= hit_flag;
    in_ch.pc        <= pc_v;
    in_ch.paddr     <= addr_v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Let every victim come back, then give a running fill time to finish
  task automatic drain_and_pause();
    int waited;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (victims_owed != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic apply_settings(input int hot, input int run, input int lim);
    drain_and_pause();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOT_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(hot);
    @(negedge clk);
    cfg_index <= CFG_STREAM_RUN;
    cfg_wdata <= CFG_DATA_W'(run);
    @(negedge clk);
    cfg_index <= CFG_SMALL_STRIDE;
    cfg_wdata <= CFG_DATA_W'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_limit = lim;
  endtask

  // Victim requests, hits and fills; fills mostly follow per-PC address walks
  task automatic random_burst(input int n);
    int i;
    int r;
    int p;
    logic [PC_W-1:0] pc_v;
    logic [ADDR_W-1:0] addr_v;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send(OP_VICTIM, pick_set(), WAY_IN_W'($urandom), 1'($urandom), rand64(), rand64());
      end else if (r < 62) begin
        send(OP_UPDATE, pick_set(), WAY_IN_W'($urandom), 1'b1, rand64(), rand64());
      end else begin
        if ($urandom_range(0, 99) < 92) begin
          p = $urandom_range(0, N_PCS - 1);
          r = $urandom_range(0, 99);
          if (r < 8) stride_blk[p] = new_stride();
          if (r >= 93) cursor[p] = rand64();
          else cursor[p] = cursor[p] + ADDR_W'(stride_blk[p] * 64);
          pc_v = pc_pool[p];
          addr_v = {cursor[p][ADDR_W-1:BLOCK_SHIFT], BLOCK_SHIFT'($urandom)};
        end else begin
          pc_v = rand64();
          addr_v = rand64();
        end
        send(OP_UPDATE, pick_set(), WAY_IN_W'($urandom), 1'b0, pc_v, addr_v);
      end
    end
  endtask

  // Result side: random stalls, with quiet stretches
  initial begin
    int hold;
    hold = 0;
    out_steady = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 127) == 0) out_steady = !out_steady;
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) hold = idle_len(out_steady);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_VICTIM;
    in_ch.set_index = '0;
    in_ch.way_index = '0;
    in_ch.hit = 1'b0;
    in_ch.pc = '0;
    in_ch.paddr = '0;
    calm = 1'b0;
    cur_limit = SMALL_STRIDE_RST;
    for (i = 0; i < N_PCS; i++) begin
      pc_pool[i] = rand64();
      cursor[i] = rand64();
      stride_blk[i] = new_stride();
    end
    // two PCs sharing one signature
    pc_pool[1] = pc_pool[0] ^ {($urandom | 32'h1), 32'h0};
    set_pool[0] = '0;
    set_pool[1] = '1;
    for (i = 2; i < N_SETS; i++) set_pool[i] = SET_W'($urandom);
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset register values
    send(OP_VICTIM, '0, '0, 1'b0, '0, '0);
    send(OP_VICTIM, '1, '1, 1'b1, '1, '1);
    send(OP_UPDATE, '0, '1, 1'b0, '1, '1);
    send(OP_UPDATE, '0, '0, 1'b0, '0, '0);
    send(OP_VICTIM, '0, '0, 1'b0, '0, '0);
    // first hit since fill, then a repeated hit
    send(OP_UPDATE, '0, '1, 1'b1, '0, '0);
    send(OP_UPDATE, '0, '1, 1'b1, '0, '0);
    // unit-stride stream under one signature
    for (i = 0; i < 4; i++)
      send(OP_UPDATE, 11'd5, WAY_IN_W'(i), 1'b0, STREAM_PC,
           64'h0000_0001_0000_0000 + 64'(i * 64));
    // descending stride at the bound, then one just past it
    for (i = 0; i < 4; i++)
      send(OP_UPDATE, 11'd6, WAY_IN_W'(i), 1'b0, DOWN_PC,
           64'h0000_0002_0000_0000 - 64'(i * 8 * 64));
    send(OP_UPDATE, 11'd6, 4'd4, 1'b0, DOWN_PC, 64'h0000_0002_0000_0000 - 64'(33 * 64));
    // refill with the evicted block's own signature
    send(OP_UPDATE, '0, '0, 1'b0, '0, '0);
    send(OP_VICTIM, 11'd5, '0, 1'b0, '0, '0);
    send(OP_VICTIM, 11'd6, '0, 1'b0, '0, '0);
    send(OP_UPDATE, 11'd5, '0, 1'b1, '0, '0);
    send(OP_UPDATE, '1, '1, 1'b0, 64'h8000_0000_0000_0003, rand64());
    send(OP_VICTIM, '1, '0, 1'b0, '0, '0);

    // Random part across register settings
    apply_settings(0, 0, 0);
    random_burst(240);
    apply_settings(3, 255, 255);
    random_burst(240);
    apply_settings(3, 1, 8);
    random_burst(240);
    apply_settings(2, 3, 16);
    random_burst(240);
    apply_settings($urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 255));
    random_burst(240);
    apply_settings(1, 2, 4);
    random_burst(240);

    drain_and_pause();
    if (victims_owed != 0)
      $display("ERROR %0d victim results never arrived", victims_owed);
    if (mismatches == 0 && victims_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
design/ssrs_pkg.sv
design/ssrs_if.sv
design/ssrs_victim.sv
design/ship_srrip_stream_replacement_top.sv
design/ssrs_checker.sv
tb/sv/ssrs_victim_checker.sv
tb/sv/tb_ship_srrip_stream_replacement_top.sv
